@@ hw/rtl/iehw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker package
// Shared types, status codes and header constants for the walker.
// ----------------------------------------------------------------------------
package iehw_pkg;

    // Default width of the internal position and length counters.
    localparam int LENGTH_BITS_DEF = 16;

    // Next header values that the walker recognises.
    localparam logic [7:0] HT_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] HT_TCP        = 8'd6;
    localparam logic [7:0] HT_UDP        = 8'd17;
    localparam logic [7:0] HT_ROUTING    = 8'd43;
    localparam logic [7:0] HT_FRAGMENT   = 8'd44;
    localparam logic [7:0] HT_ICMPV6     = 8'd58;
    localparam logic [7:0] HT_NO_NEXT    = 8'd59;
    localparam logic [7:0] HT_DEST_OPTS  = 8'd60;

    // Minimum bytes of a length-coded header before its length is known.
    localparam int EXT_MIN_LEN       = 2;
    // Fixed size of a fragment header.
    localparam int FRAG_LEN          = 8;
    // Byte offsets inside headers.
    localparam int EXT_LEN_IDX       = 1;
    localparam int FRAG_OFS_HI_IDX   = 2;
    localparam int FRAG_OFS_LO_IDX   = 3;
    localparam int FRAG_ID_FIRST_IDX = 4;
    localparam int FRAG_ID_LAST_IDX  = 7;
    // The fragment offset sits above the three flag bits.
    localparam int FRAG_OFS_SHIFT    = 3;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TRUNC      = 3'd1,
        ST_TRUNC_FRAG = 3'd2,
        ST_NONFIRST   = 3'd3,
        ST_UNSUP      = 3'd4
    } t_status;

    // One input item.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        first_item;
        logic        last_item;
        logic [7:0]  start_next_header;
        logic [15:0] payload_length;
        logic [15:0] captured_length;
    } t_in_item;

    // One result item.
    typedef struct packed {
        t_status            status;
        logic [7:0]         upper_protocol;
        logic [15:0]        upper_offset;
        logic signed [16:0] upper_length;
        logic               fragment_seen;
        logic               more_fragments;
        logic [31:0]        fragment_ident;
    } t_out_item;

endpackage

@@ hw/rtl/iehw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker channels
// Valid/ready channel interfaces for payload bytes and walk results.
// ----------------------------------------------------------------------------
interface iehw_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        first_item;
    logic        last_item;
    logic [7:0]  start_next_header;
    logic [15:0] payload_length;
    logic [15:0] captured_length;

    modport source (
        output valid, data_byte, byte_present, first_item, last_item,
               start_next_header, payload_length, captured_length,
        input  ready
    );
    modport sink (
        input  valid, data_byte, byte_present, first_item, last_item,
               start_next_header, payload_length, captured_length,
        output ready
    );
endinterface

interface iehw_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         upper_protocol;
    logic [15:0]        upper_offset;
    logic signed [16:0] upper_length;
    logic               fragment_seen;
    logic               more_fragments;
    logic [31:0]        fragment_ident;

    modport source (
        output valid, status, upper_protocol, upper_offset, upper_length,
               fragment_seen, more_fragments, fragment_ident,
        input  ready
    );
    modport sink (
        input  valid, status, upper_protocol, upper_offset, upper_length,
               fragment_seen, more_fragments, fragment_ident,
        output ready
    );
endinterface

@@ hw/rtl/iehw_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker step
// Holds the walk state and processes one payload byte per advance.
// ----------------------------------------------------------------------------
module iehw_step #(
    parameter int LENGTH_BITS = iehw_pkg::LENGTH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  iehw_pkg::t_in_item  i_item,
    output logic                o_emit,
    output iehw_pkg::t_out_item o_result
);

    // Width for bound sums: holds a position plus the largest header size.
    localparam int SUM_W = (LENGTH_BITS < 12) ? 13 :
                           ((LENGTH_BITS < 32) ? LENGTH_BITS + 1 : 32);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WALK = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef struct packed {
        logic              hit;
        iehw_pkg::t_status status;
        logic [11:0]       size;
    } t_enter;

    t_phase                  r_phase, n_phase;
    logic [7:0]              r_type, n_type;
    logic [LENGTH_BITS-1:0]  r_pos, n_pos;
    logic [LENGTH_BITS-1:0]  r_hs, n_hs;
    logic [11:0]             r_hsize, n_hsize;
    logic [7:0]              r_latched, n_latched;
    logic [LENGTH_BITS-1:0]  r_lim, n_lim;
    logic [LENGTH_BITS-1:0]  r_pl, n_pl;
    logic [7:0]              r_ohb, n_ohb;
    logic                    r_fseen, n_fseen;
    logic                    r_fmore, n_fmore;
    logic [31:0]             r_fid, n_fid;

    logic                    w_emit;
    iehw_pkg::t_status       w_status;
    iehw_pkg::t_out_item     w_result;

    // Checks a header that starts at hs against the payload and capture bounds.
    function automatic t_enter enter_hdr(
        input logic [7:0]             t,
        input logic [LENGTH_BITS-1:0] hs,
        input logic [LENGTH_BITS-1:0] pl,
        input logic [LENGTH_BITS-1:0] lim
    );
        t_enter           e;
        logic [SUM_W-1:0] hs_w;
        logic [SUM_W-1:0] pl_w;
        logic [SUM_W-1:0] lim_w;
        logic [SUM_W-1:0] rem;
        hs_w     = SUM_W'(hs);
        pl_w     = SUM_W'(pl);
        lim_w    = SUM_W'(lim);
        rem      = (pl_w >= hs_w) ? pl_w - hs_w : '0;
        e.hit    = 1'b0;
        e.status = iehw_pkg::ST_OK;
        e.size   = '0;
        if (t == iehw_pkg::HT_TCP || t == iehw_pkg::HT_UDP ||
            t == iehw_pkg::HT_ICMPV6 || t == iehw_pkg::HT_NO_NEXT) begin
            e.hit = 1'b1;
        end else if (t == iehw_pkg::HT_HOP_BY_HOP || t == iehw_pkg::HT_ROUTING ||
                     t == iehw_pkg::HT_DEST_OPTS) begin
            if (pl_w < hs_w || rem < SUM_W'(iehw_pkg::EXT_MIN_LEN) ||
                lim_w < hs_w + SUM_W'(iehw_pkg::EXT_MIN_LEN)) begin
                e.hit    = 1'b1;
                e.status = iehw_pkg::ST_TRUNC;
            end
        end else if (t == iehw_pkg::HT_FRAGMENT) begin
            if (pl_w < hs_w || rem < SUM_W'(iehw_pkg::FRAG_LEN) ||
                lim_w < hs_w + SUM_W'(iehw_pkg::FRAG_LEN)) begin
                e.hit    = 1'b1;
                e.status = iehw_pkg::ST_TRUNC_FRAG;
            end else begin
                e.size = 12'(iehw_pkg::FRAG_LEN);
            end
        end else begin
            e.hit    = 1'b1;
            e.status = iehw_pkg::ST_UNSUP;
        end
        return e;
    endfunction

    // Step logic: packet start, then the present byte, then the packet end.
    always_comb begin
        t_enter                 e;
        logic                   stop;
        logic                   done;
        logic [LENGTH_BITS-1:0] idx;
        logic [8:0]             len_p1;
        logic [11:0]            need;
        logic [SUM_W-1:0]       hs_w;
        logic [SUM_W-1:0]       pl_w;
        logic [SUM_W-1:0]       lim_w;
        logic [SUM_W-1:0]       rem;
        logic [15:0]            frag_ofs;

        n_phase   = r_phase;
        n_type    = r_type;
        n_pos     = r_pos;
        n_hs      = r_hs;
        n_hsize   = r_hsize;
        n_latched = r_latched;
        n_lim     = r_lim;
        n_pl      = r_pl;
        n_ohb     = r_ohb;
        n_fseen   = r_fseen;
        n_fmore   = r_fmore;
        n_fid     = r_fid;
        w_emit    = 1'b0;
        w_status  = iehw_pkg::ST_OK;
        stop      = 1'b0;
        done      = 1'b0;
        e         = '0;
        idx       = '0;
        len_p1    = '0;
        need      = '0;
        hs_w      = '0;
        pl_w      = '0;
        lim_w     = '0;
        rem       = '0;
        frag_ofs  = '0;

        // A new packet restarts the walk and examines the first header.
        if (i_item.first_item) begin
            n_phase   = PH_WALK;
            n_type    = i_item.start_next_header;
            n_pl      = LENGTH_BITS'(i_item.payload_length);
            n_lim     = LENGTH_BITS'(i_item.captured_length);
            n_pos     = '0;
            n_hs      = '0;
            n_hsize   = '0;
            n_latched = '0;
            n_ohb     = '0;
            n_fseen   = 1'b0;
            n_fmore   = 1'b0;
            n_fid     = '0;
            e = enter_hdr(n_type, n_hs, n_pl, n_lim);
            if (e.hit) begin
                w_emit   = 1'b1;
                w_status = e.status;
                stop     = 1'b1;
            end else begin
                n_hsize = e.size;
            end
        end

        if (!stop && n_phase == PH_WALK) begin
            // Consume one byte of the current header.
            if (i_item.byte_present) begin
                idx = n_pos - n_hs;
                if (idx == '0) begin
                    n_latched = i_item.data_byte;
                end
                if (n_type == iehw_pkg::HT_FRAGMENT) begin
                    if (idx == LENGTH_BITS'(iehw_pkg::FRAG_OFS_HI_IDX)) begin
                        n_ohb = i_item.data_byte;
                    end
                    if (idx == LENGTH_BITS'(iehw_pkg::FRAG_OFS_LO_IDX)) begin
                        frag_ofs = {n_ohb, i_item.data_byte} >> iehw_pkg::FRAG_OFS_SHIFT;
                        if (frag_ofs != 16'd0) begin
                            w_emit   = 1'b1;
                            w_status = iehw_pkg::ST_NONFIRST;
                            stop     = 1'b1;
                        end else begin
                            n_fmore = i_item.data_byte[0];
                        end
                    end
                    if (SUM_W'(idx) >= SUM_W'(iehw_pkg::FRAG_ID_FIRST_IDX) &&
                        SUM_W'(idx) <= SUM_W'(iehw_pkg::FRAG_ID_LAST_IDX)) begin
                        n_fid = {n_fid[23:0], i_item.data_byte};
                    end
                    if (idx == LENGTH_BITS'(iehw_pkg::FRAG_ID_LAST_IDX)) begin
                        n_fseen = 1'b1;
                        done    = 1'b1;
                    end
                end else begin
                    // The length byte fixes the header size and is checked at once.
                    if (idx == LENGTH_BITS'(iehw_pkg::EXT_LEN_IDX)) begin
                        len_p1  = {1'b0, i_item.data_byte} + 9'd1;
                        need    = {len_p1, 3'b000};
                        n_hsize = need;
                        hs_w    = SUM_W'(n_hs);
                        pl_w    = SUM_W'(n_pl);
                        lim_w   = SUM_W'(n_lim);
                        rem     = (pl_w >= hs_w) ? pl_w - hs_w : '0;
                        if (rem < SUM_W'(need) || lim_w < hs_w + SUM_W'(need)) begin
                            w_emit   = 1'b1;
                            w_status = iehw_pkg::ST_TRUNC;
                            stop     = 1'b1;
                        end
                    end
                    if (!stop && SUM_W'(idx) >= SUM_W'(iehw_pkg::FRAG_ID_LAST_IDX) &&
                        n_hsize != 12'd0 &&
                        SUM_W'(idx) == SUM_W'(n_hsize - 12'd1)) begin
                        done = 1'b1;
                    end
                end
                if (!stop) begin
                    n_pos = n_pos + LENGTH_BITS'(1);
                    // Header complete: move on to the one it names.
                    if (done) begin
                        n_type = n_latched;
                        n_hs   = n_pos;
                        e = enter_hdr(n_type, n_hs, n_pl, n_lim);
                        if (e.hit) begin
                            w_emit   = 1'b1;
                            w_status = e.status;
                            stop     = 1'b1;
                        end else begin
                            n_hsize = e.size;
                        end
                    end
                end
            end
            // The packet ended before the walk reached a decision.
            if (!stop && i_item.last_item) begin
                w_emit   = 1'b1;
                w_status = (n_type == iehw_pkg::HT_FRAGMENT) ? iehw_pkg::ST_TRUNC_FRAG
                                                             : iehw_pkg::ST_TRUNC;
            end
        end

        if (w_emit) begin
            n_phase = PH_DONE;
        end
    end

    // Result fields: protocol, offset and length only on success.
    always_comb begin
        w_result.status         = w_status;
        w_result.fragment_seen  = n_fseen;
        w_result.more_fragments = n_fmore;
        w_result.fragment_ident = n_fid;
        if (w_status == iehw_pkg::ST_OK) begin
            w_result.upper_protocol = n_type;
            w_result.upper_offset   = 16'(n_hs);
            w_result.upper_length   = 17'(n_pl - n_hs);
        end else begin
            w_result.upper_protocol = '0;
            w_result.upper_offset   = '0;
            w_result.upper_length   = '0;
        end
    end

    assign o_emit   = i_adv & w_emit;
    assign o_result = w_result;

    // Walk state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_adv) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_type    <= n_type;
            r_pos     <= n_pos;
            r_hs      <= n_hs;
            r_hsize   <= n_hsize;
            r_latched <= n_latched;
            r_lim     <= n_lim;
            r_pl      <= n_pl;
            r_ohb     <= n_ohb;
            r_fseen   <= n_fseen;
            r_fmore   <= n_fmore;
            r_fid     <= n_fid;
        end
    end

    // A result always closes the walk of its packet.
    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_emit) |=> (r_phase == PH_DONE))
        else $error("walk still open after a result");

    // Bytes outside a packet never produce a result.
    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_item.first_item && r_phase != PH_WALK) |-> !w_emit)
        else $error("result produced outside a packet");

    // Success is only reported for an upper-layer protocol.
    a_ok_protocol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_emit && w_status == iehw_pkg::ST_OK) |->
        (w_result.upper_protocol == iehw_pkg::HT_TCP ||
         w_result.upper_protocol == iehw_pkg::HT_UDP ||
         w_result.upper_protocol == iehw_pkg::HT_ICMPV6 ||
         w_result.upper_protocol == iehw_pkg::HT_NO_NEXT))
        else $error("success reported for a non upper-layer header");

    // A non-first fragment can only be found inside a fragment header.
    a_nonfirst_in_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_emit && w_status == iehw_pkg::ST_NONFIRST) |->
        (r_type == iehw_pkg::HT_FRAGMENT && !i_item.first_item))
        else $error("non-first fragment outside a fragment header");

endmodule

@@ hw/rtl/ipv6_extension_header_walker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker
// Follows the extension header chain of an IPv6 payload, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
// The input channel i_in carries one payload byte per transfer. The transfer
// with first_item set also brings the initial next header value, the payload
// length and the captured length, and restarts the walk. The output channel
// o_out carries at most one result per packet: success with the upper-layer
// protocol, its offset and remaining length, or an error status, always with
// the fragment identification and more-fragments flag seen so far.
// Throughput is one input transfer per cycle while o_out is not stalled. An
// accepted item lands in an input register and is processed by the step
// logic once the output register is free or being emptied; the result of the
// deciding byte is registered in the output register before o_out offers it.
// Reset clears the valid flags and returns the walk to idle; bytes that
// arrive before a first item are ignored.
// While the receiver stalls, the pending result holds in the output register
// and one further item is still taken into the input register; the input
// then stalls until the result is taken.
// ----------------------------------------------------------------------------
module ipv6_extension_header_walker_top #(
    parameter int LENGTH_BITS = iehw_pkg::LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iehw_in_if.sink    i_in,
    iehw_out_if.source o_out
);

    logic                r_in_valid, n_in_valid;
    iehw_pkg::t_in_item  r_in;
    logic                r_out_valid, n_out_valid;
    iehw_pkg::t_out_item r_out;
    logic                w_adv;
    logic                w_in_take;
    logic                w_emit;
    iehw_pkg::t_out_item w_result;

    // The held item advances when the output register is free or being emptied.
    assign w_adv     = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready = ~r_in_valid | w_adv;
    assign w_in_take = i_in.valid & i_in.ready;

    iehw_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_in),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    // Next state of the valid flags.
    always_comb begin
        n_in_valid  = w_in_take ? 1'b1 : (w_adv ? 1'b0 : r_in_valid);
        n_out_valid = w_emit ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.data_byte         <= i_in.data_byte;
            r_in.byte_present      <= i_in.byte_present;
            r_in.first_item        <= i_in.first_item;
            r_in.last_item         <= i_in.last_item;
            r_in.start_next_header <= i_in.start_next_header;
            r_in.payload_length    <= i_in.payload_length;
            r_in.captured_length   <= i_in.captured_length;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.upper_protocol = r_out.upper_protocol;
    assign o_out.upper_offset   = r_out.upper_offset;
    assign o_out.upper_length   = r_out.upper_length;
    assign o_out.fragment_seen  = r_out.fragment_seen;
    assign o_out.more_fragments = r_out.more_fragments;
    assign o_out.fragment_ident = r_out.fragment_ident;

endmodule
